### rtl/okp_pkg.sv
// ----------------------------------------------------------------------------
// Reply packet field parser package
// Shared types, constants and phase encoding for the reply field parser.
// ----------------------------------------------------------------------------
package okp_pkg;

  localparam int POS_BITS            = 24;
  localparam int SESSION_CHANGED_BIT = 14;
  localparam int MIN_PACKET          = 7;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [7:0] PFX_NULL = 8'hfb;
  localparam logic [7:0] PFX_TWO  = 8'hfc;
  localparam logic [7:0] PFX_FOUR = 8'hfd;
  localparam logic [7:0] PFX_EIGHT = 8'hfe;

  localparam logic [1:0] CODE_OK     = 2'd0;
  localparam logic [1:0] CODE_SHORT  = 2'd1;
  localparam logic [1:0] CODE_PREFIX = 2'd2;
  localparam logic [1:0] CODE_TRUNC  = 2'd3;

  localparam logic [1:0] REG_PROTO41  = 2'd0;
  localparam logic [1:0] REG_TRANS    = 2'd1;
  localparam logic [1:0] REG_SESSTRK  = 2'd2;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_ROWS      = 4'd1,
    PH_ID        = 4'd2,
    PH_STATUS    = 4'd3,
    PH_WARN      = 4'd4,
    PH_INFO_LEN  = 4'd5,
    PH_INFO_DATA = 4'd6,
    PH_INFO_RAW  = 4'd7,
    PH_SESS_LEN  = 4'd8,
    PH_SESS_DATA = 4'd9,
    PH_ERROR     = 4'd10
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status_code;
    logic [63:0]         row_count;
    logic [63:0]         insert_id;
    logic [15:0]         server_status;
    logic [15:0]         warning_count;
    logic [POS_BITS-1:0] info_offset;
    logic [POS_BITS-1:0] info_length;
    logic                session_present;
    logic [POS_BITS-1:0] session_offset;
    logic [POS_BITS-1:0] session_length;
  } out_item_t;

  // Classified byte handed from the front to the back part.
  typedef struct packed {
    logic [7:0]          data_byte;
    logic                last_byte;
    logic [POS_BITS-1:0] pos;    // position of this byte
    logic [POS_BITS-1:0] nxt;    // saturated position after it
    logic                short_pkt;
  } tok_t;

  typedef struct packed {
    logic proto41;
    logic trans;
    logic sesstrk;
  } caps_t;

endpackage

### rtl/okp_front.sv
// ----------------------------------------------------------------------------
// Reply parser front end
// Accepts bytes, tracks the saturating byte position and tags each byte.
// ----------------------------------------------------------------------------
module okp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  okp_pkg::in_item_t in_data,
  output logic            tok_valid,
  output okp_pkg::tok_t   tok,
  input  logic            tok_ready
);
  import okp_pkg::*;

  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] inc;
  logic                take;

  assign in_full   = !tok_ready;
  assign take      = in_push && tok_ready;
  assign inc       = (&pos_r) ? pos_r : pos_r + 1'b1;
  assign tok_valid = in_push;

  always_comb begin
    tok.data_byte = in_data.data_byte;
    tok.last_byte = in_data.last_byte;
    tok.pos       = pos_r;
    tok.nxt       = inc;
    tok.short_pkt = ({{(32-POS_BITS){1'b0}}, inc} < 32'(MIN_PACKET));
  end

  always_comb begin
    pos_nxt = pos_r;
    if (take) begin
      pos_nxt = in_data.last_byte ? '0 : inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

### rtl/okp_fifo.sv
// ----------------------------------------------------------------------------
// Reply parser token queue
// Two-entry queue that decouples the front end from the field decoder.
// ----------------------------------------------------------------------------
module okp_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  okp_pkg::tok_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output okp_pkg::tok_t rd_data
);
  import okp_pkg::*;

  tok_t       mem_r [QUEUE_DEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wr ? !wp_r : wp_r;
    rp_nxt  = rd ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

### rtl/okp_back.sv
// ----------------------------------------------------------------------------
// Reply parser field decoder
// Decodes fields one byte per cycle unless the one result register stalls it.
// ----------------------------------------------------------------------------
module okp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  okp_pkg::caps_t     caps,
  input  logic               tok_valid,
  output logic               tok_ready,
  input  okp_pkg::tok_t      tok,
  output logic               out_empty,
  input  logic               out_pop,
  output okp_pkg::out_item_t out_data
);
  import okp_pkg::*;

  phase_t              ph_r, ph_nxt;
  logic [3:0]          pend_r, pend_nxt;
  logic [3:0]          fsize_r, fsize_nxt;
  logic [63:0]         acc_r, acc_nxt;
  logic [63:0]         rows_r, rows_nxt, iid_r, iid_nxt;
  logic [15:0]         stat_r, stat_nxt, warn_r, warn_nxt;
  logic [POS_BITS-1:0] istart_r, istart_nxt, sstart_r, sstart_nxt;
  logic [63:0]         idecl_r, idecl_nxt, sdecl_r, sdecl_nxt;
  logic                err_r, err_nxt;
  logic                full_r;
  out_item_t           res_r, res_nxt;

  logic        step, done, lenenc, fixed, fin;
  logic [7:0]  b;
  logic [63:0] ibyte;
  logic [2:0]  k;
  logic [POS_BITS-1:0] nx, irem, srem;
  logic [63:0] idelta;

  assign tok_ready = !full_r || out_pop;
  assign step      = tok_valid && tok_ready;
  assign out_empty = !full_r;
  assign out_data  = res_r;
  assign b         = tok.data_byte;
  assign nx        = tok.nxt;
  assign k         = 3'(fsize_r - pend_r);
  assign ibyte     = {56'd0, b} << {k, 3'b000};
  assign idelta    = 64'(tok.pos - istart_r);

  // Field decode for one byte.
  always_comb begin
    ph_nxt = ph_r; pend_nxt = pend_r; fsize_nxt = fsize_r; acc_nxt = acc_r;
    rows_nxt = rows_r; iid_nxt = iid_r; stat_nxt = stat_r; warn_nxt = warn_r;
    istart_nxt = istart_r; idecl_nxt = idecl_r; sstart_nxt = sstart_r;
    sdecl_nxt = sdecl_r; err_nxt = err_r;
    done = 1'b0; lenenc = 1'b0; fixed = 1'b0;
    unique case (ph_r)
      PH_HEADER: begin
        ph_nxt = PH_ROWS; pend_nxt = '0;
      end
      PH_ROWS, PH_ID, PH_INFO_LEN, PH_SESS_LEN: lenenc = 1'b1;
      PH_STATUS, PH_WARN: fixed = 1'b1;
      PH_INFO_DATA: begin
        if (idelta >= idecl_r && stat_r[SESSION_CHANGED_BIT]) begin
          ph_nxt = PH_SESS_LEN; pend_nxt = '0; lenenc = 1'b1;
        end
      end
      default: ;
    endcase
    if (fixed) begin
      if (pend_r == 4'd0) begin
        done = 1'b1;
      end else begin
        acc_nxt = acc_r | ibyte; pend_nxt = pend_r - 4'd1;
        done = (pend_r == 4'd1);
      end
    end
    if (lenenc) begin
      if (pend_r != 4'd0 && ph_r != PH_INFO_DATA) begin
        acc_nxt = acc_r | ibyte; pend_nxt = pend_r - 4'd1;
        done = (pend_r == 4'd1);
      end else if (b < PFX_NULL) begin
        acc_nxt = {56'd0, b}; done = 1'b1;
      end else if (b == PFX_TWO || b == PFX_FOUR || b == PFX_EIGHT) begin
        acc_nxt = '0;
        fsize_nxt = (b == PFX_TWO) ? 4'd2 : (b == PFX_FOUR) ? 4'd3 : 4'd8;
        pend_nxt = fsize_nxt;
      end else begin
        err_nxt = 1'b1; ph_nxt = PH_ERROR;
      end
    end
    if (done) begin
      unique case (ph_nxt)
        PH_ROWS: begin
          rows_nxt = acc_nxt; ph_nxt = PH_ID; pend_nxt = '0;
        end
        PH_ID: begin
          iid_nxt = acc_nxt;
          if (caps.proto41 || caps.trans) begin
            ph_nxt = PH_STATUS; fsize_nxt = 4'd2; pend_nxt = 4'd2; acc_nxt = '0;
          end else begin
            istart_nxt = nx; pend_nxt = '0;
            ph_nxt = caps.sesstrk ? PH_INFO_LEN : PH_INFO_RAW;
          end
        end
        PH_STATUS: begin
          stat_nxt = acc_nxt[15:0];
          if (caps.proto41) begin
            ph_nxt = PH_WARN; fsize_nxt = 4'd2; pend_nxt = 4'd2; acc_nxt = '0;
          end else begin
            istart_nxt = nx; pend_nxt = '0;
            ph_nxt = caps.sesstrk ? PH_INFO_LEN : PH_INFO_RAW;
          end
        end
        PH_WARN: begin
          warn_nxt = acc_nxt[15:0]; istart_nxt = nx; pend_nxt = '0;
          ph_nxt = caps.sesstrk ? PH_INFO_LEN : PH_INFO_RAW;
        end
        PH_INFO_LEN: begin
          idecl_nxt = acc_nxt; istart_nxt = nx; ph_nxt = PH_INFO_DATA;
        end
        PH_SESS_LEN: begin
          sdecl_nxt = acc_nxt; sstart_nxt = nx; ph_nxt = PH_SESS_DATA;
        end
        default: ;
      endcase
    end
  end

  // Result assembly on the final byte.
  assign irem = (nx >= istart_nxt) ? nx - istart_nxt : '0;
  assign srem = (nx >= sstart_nxt) ? nx - sstart_nxt : '0;

  always_comb begin
    res_nxt = '0;
    res_nxt.status_code = CODE_OK;
    if (tok.short_pkt) begin
      res_nxt.status_code = CODE_SHORT;
    end else if (err_nxt) begin
      res_nxt.status_code = CODE_PREFIX;
    end else begin
      unique case (ph_nxt)
        PH_INFO_LEN: begin
          if (pend_nxt != 4'd0) res_nxt.status_code = CODE_TRUNC;
          else res_nxt.info_offset = istart_nxt;
        end
        PH_INFO_RAW: begin
          res_nxt.info_offset = istart_nxt;
          res_nxt.info_length = nx - istart_nxt;
        end
        PH_INFO_DATA: begin
          res_nxt.info_offset = istart_nxt;
          res_nxt.info_length = (idecl_nxt < 64'(irem)) ? idecl_nxt[POS_BITS-1:0] : irem;
          if (stat_nxt[SESSION_CHANGED_BIT]) begin
            res_nxt.session_present = 1'b1;
            res_nxt.session_offset  = nx;
          end
        end
        PH_SESS_DATA: begin
          res_nxt.info_offset     = istart_nxt;
          res_nxt.info_length     = idecl_nxt[POS_BITS-1:0];
          res_nxt.session_present = 1'b1;
          res_nxt.session_offset  = sstart_nxt;
          res_nxt.session_length  =
            (sdecl_nxt < 64'(srem)) ? sdecl_nxt[POS_BITS-1:0] : srem;
        end
        default: res_nxt.status_code = CODE_TRUNC;
      endcase
    end
    if (res_nxt.status_code == CODE_OK) begin
      res_nxt.row_count      = rows_nxt;
      res_nxt.insert_id      = iid_nxt;
      res_nxt.server_status  = stat_nxt;
      res_nxt.warning_count  = warn_nxt;
    end
  end

  assign fin = step && tok.last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n || fin) begin
      ph_r <= PH_HEADER; pend_r <= '0; fsize_r <= '0; acc_r <= '0;
      rows_r <= '0; iid_r <= '0; stat_r <= '0; warn_r <= '0;
      istart_r <= '0; idecl_r <= '0; sstart_r <= '0; sdecl_r <= '0; err_r <= 1'b0;
    end else if (step) begin
      ph_r <= ph_nxt; pend_r <= pend_nxt; fsize_r <= fsize_nxt; acc_r <= acc_nxt;
      rows_r <= rows_nxt; iid_r <= iid_nxt; stat_r <= stat_nxt; warn_r <= warn_nxt;
      istart_r <= istart_nxt; idecl_r <= idecl_nxt; sstart_r <= sstart_nxt;
      sdecl_r <= sdecl_nxt; err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (fin) begin
      full_r <= 1'b1;
    end else if (out_pop) begin
      full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      res_r <= res_nxt;
    end
  end

endmodule

### rtl/ok_packet_field_parser_top.sv
// ----------------------------------------------------------------------------
// Reply packet field parser top level
// Streams reply payload bytes and reports the decoded fields once per packet.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, set by the single-byte decode step, unless a full result register stalls it.
// Result: a packet's final byte is first written into the token queue, and its
// result is registered at the edge where the decoder takes that byte from the queue.
// Reset: rst_n is synchronous and active low; it empties the token queue and the
// result register, returns the decoder to the header phase and restores the capability registers.
module ok_packet_field_parser_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  okp_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output okp_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import okp_pkg::*;

  // Capability registers, written through the configuration port.
  caps_t caps_r, caps_nxt;
  logic  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    caps_nxt = caps_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_PROTO41: caps_nxt.proto41 = cfg_pwdata[0];
        REG_TRANS:   caps_nxt.trans   = cfg_pwdata[0];
        REG_SESSTRK: caps_nxt.sesstrk = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[3:2])
      REG_PROTO41: cfg_prdata[0] = caps_r.proto41;
      REG_TRANS:   cfg_prdata[0] = caps_r.trans;
      REG_SESSTRK: cfg_prdata[0] = caps_r.sesstrk;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caps_r <= '{proto41: 1'b1, trans: 1'b0, sesstrk: 1'b0};
    end else begin
      caps_r <= caps_nxt;
    end
  end

  // The front end tags each byte with its position; the queue absorbs bytes
  // while the decoder stalls on a full result register, until the queue is full.
  logic f_valid, f_ready, q_valid, q_ready;
  tok_t f_tok, q_tok;

  okp_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .tok_valid(f_valid), .tok(f_tok), .tok_ready(f_ready)
  );

  okp_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_tok),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_tok)
  );

  okp_back u_back (
    .clk, .rst_n, .caps(caps_r),
    .tok_valid(q_valid), .tok_ready(q_ready), .tok(q_tok),
    .out_empty, .out_pop, .out_data
  );

`ifndef NO_ASSERTIONS
  // A non-ok result never carries decoded fields.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.status_code != CODE_OK) |->
      (out_data.row_count == '0 && out_data.info_length == '0))
    else $error("error result carries field data");

  // A waiting result that is not popped stays unchanged.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("pending result changed");

  // Session fields are zero whenever no session string is reported.
  a_sess: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.session_present) |->
      (out_data.session_offset == '0 && out_data.session_length == '0))
    else $error("session fields without session");
`endif

endmodule

### dv/ok_packet_field_parser_checker.sv
// ----------------------------------------------------------------------------
// Reply packet field parser checker
// Watches the request, result and register ports, predicts each packet's
// decoded fields and compares them with the results the block hands out.
// ----------------------------------------------------------------------------
module ok_packet_field_parser_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  okp_pkg::in_item_t  in_data,
  input  logic               out_empty,
  input  logic               out_pop,
  input  okp_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 fail_count,
  output int                 results_owed
);
  import okp_pkg::*;

  localparam logic [POS_BITS-1:0] POS_TOP = '1;

  logic              cap_p41, cap_trans, cap_sess;
  logic [POS_BITS-1:0] pos;
  phase_t            ph;
  int                pend, fsize;
  logic [63:0]       acc, rows, ins_id, info_beg, info_decl, sess_beg, sess_decl;
  logic [15:0]       stat_word, warn_word;
  logic [1:0]        err;
  out_item_t         packet_results[$];

  task automatic clear_packet();
    pos = '0; ph = PH_HEADER; pend = 0; fsize = 0; acc = '0; rows = '0; ins_id = '0;
    stat_word = '0; warn_word = '0; info_beg = '0; info_decl = '0;
    sess_beg = '0; sess_decl = '0; err = '0;
  endtask

  task automatic take_body(input logic [7:0] b, output bit done);
    acc |= 64'(b) << (8 * ((fsize - pend) & 7));
    pend--;
    done = (pend == 0);
  endtask

  // Length-encoded integer: a small byte is the value, a prefix announces more.
  task automatic take_lenenc(input logic [7:0] b, output bit done);
    done = 0;
    if (pend != 0) begin
      take_body(b, done);
    end else if (b < PFX_NULL) begin
      acc = 64'(b);
      done = 1;
    end else if (b == PFX_TWO || b == PFX_FOUR || b == PFX_EIGHT) begin
      fsize = (b == PFX_TWO) ? 2 : (b == PFX_FOUR) ? 3 : 8;
      pend = fsize;
      acc = '0;
    end else begin
      err = CODE_PREFIX;
      ph = PH_ERROR;
    end
  endtask

  task automatic start_word(input phase_t p);
    ph = p; fsize = 2; pend = 2; acc = '0;
  endtask

  task automatic enter_tail(input logic [63:0] nxt);
    info_beg = nxt;
    pend = 0;
    ph = cap_sess ? PH_INFO_LEN : PH_INFO_RAW;
  endtask

  task automatic finish_field(input logic [63:0] nxt);
    case (ph)
      PH_ROWS: begin
        rows = acc; ph = PH_ID; pend = 0;
      end
      PH_ID: begin
        ins_id = acc;
        if (cap_p41 || cap_trans) start_word(PH_STATUS);
        else enter_tail(nxt);
      end
      PH_STATUS: begin
        stat_word = acc[15:0];
        if (cap_p41) start_word(PH_WARN);
        else enter_tail(nxt);
      end
      PH_WARN: begin
        warn_word = acc[15:0];
        enter_tail(nxt);
      end
      PH_INFO_LEN: begin
        info_decl = acc; info_beg = nxt; ph = PH_INFO_DATA;
      end
      PH_SESS_LEN: begin
        sess_decl = acc; sess_beg = nxt; ph = PH_SESS_DATA;
      end
      default: ;
    endcase
  endtask

  function automatic logic [63:0] clamp(input logic [63:0] decl, beg, n);
    logic [63:0] rem;
    rem = (n >= beg) ? n - beg : 64'd0;
    return (decl < rem) ? decl : rem;
  endfunction

  task automatic take_byte(input in_item_t it);
    logic [63:0] p, nxt, n;
    bit          done;
    out_item_t   r;
    p = 64'(pos);
    nxt = (pos == POS_TOP) ? p : p + 1;
    done = 0;
    r = '0;
    case (ph)
      PH_HEADER: begin
        ph = PH_ROWS; pend = 0;
      end
      PH_ROWS, PH_ID, PH_INFO_LEN, PH_SESS_LEN: begin
        take_lenenc(it.data_byte, done);
        if (done) finish_field(nxt);
      end
      PH_STATUS, PH_WARN: begin
        if (pend == 0) done = 1;
        else take_body(it.data_byte, done);
        if (done) finish_field(nxt);
      end
      PH_INFO_DATA: begin
        // Once the info text is used up, a flagged session string follows.
        if (p - info_beg >= info_decl && stat_word[SESSION_CHANGED_BIT]) begin
          ph = PH_SESS_LEN; pend = 0;
          take_lenenc(it.data_byte, done);
          if (done) finish_field(nxt);
        end
      end
      default: ;
    endcase
    pos = POS_BITS'(nxt);
    if (!it.last_byte) return;

    n = nxt;
    if (n < MIN_PACKET) r.status_code = CODE_SHORT;
    else if (err != 0) r.status_code = CODE_PREFIX;
    else begin
      case (ph)
        PH_INFO_LEN: begin
          if (pend != 0) r.status_code = CODE_TRUNC;
          else r.info_offset = POS_BITS'(info_beg);
        end
        PH_INFO_RAW: begin
          r.info_offset = POS_BITS'(info_beg);
          r.info_length = POS_BITS'(n - info_beg);
        end
        PH_INFO_DATA: begin
          r.info_offset = POS_BITS'(info_beg);
          r.info_length = POS_BITS'(clamp(info_decl, info_beg, n));
          if (stat_word[SESSION_CHANGED_BIT]) begin
            r.session_present = 1'b1;
            r.session_offset = POS_BITS'(n);
          end
        end
        PH_SESS_DATA: begin
          r.info_offset = POS_BITS'(info_beg);
          r.info_length = POS_BITS'(info_decl);
          r.session_present = 1'b1;
          r.session_offset = POS_BITS'(sess_beg);
          r.session_length = POS_BITS'(clamp(sess_decl, sess_beg, n));
        end
        default: r.status_code = CODE_TRUNC;
      endcase
    end
    if (r.status_code == CODE_OK) begin
      r.row_count = rows;
      r.insert_id = ins_id;
      r.server_status = stat_word;
      r.warning_count = warn_word;
    end else begin
      r = '0;
      r.status_code = (n < MIN_PACKET) ? CODE_SHORT : (err != 0) ? CODE_PREFIX : CODE_TRUNC;
    end
    packet_results.push_back(r);
    clear_packet();
  endtask

  task automatic check_field(input string name, input logic [63:0] want, got);
    if (want !== got) begin
      $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (packet_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %0h", $time, got);
      fail_count++;
      return;
    end
    want = packet_results.pop_front();
    check_field("status_code", want.status_code, got.status_code);
    check_field("row_count", want.row_count, got.row_count);
    check_field("insert_id", want.insert_id, got.insert_id);
    check_field("server_status", want.server_status, got.server_status);
    check_field("warning_count", want.warning_count, got.warning_count);
    check_field("info_offset", want.info_offset, got.info_offset);
    check_field("info_length", want.info_length, got.info_length);
    check_field("session_present", want.session_present, got.session_present);
    check_field("session_offset", want.session_offset, got.session_offset);
    check_field("session_length", want.session_length, got.session_length);
  endtask

  initial begin
    fail_count = 0;
    results_owed = 0;
    cap_p41 = 1'b1; cap_trans = 1'b0; cap_sess = 1'b0;
    clear_packet();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cap_p41 = 1'b1; cap_trans = 1'b0; cap_sess = 1'b0;
      clear_packet();
      packet_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_PROTO41: cap_p41 = cfg_pwdata[0];
          REG_TRANS:   cap_trans = cfg_pwdata[0];
          REG_SESSTRK: cap_sess = cfg_pwdata[0];
          default: ;
        endcase
      end
      if (out_pop && !out_empty) check_result(out_data);
      if (in_push && !in_full) take_byte(in_data);
    end
    results_owed = packet_results.size();
  end

endmodule

### dv/ok_packet_field_parser_top_test.sv
// ----------------------------------------------------------------------------
// Reply packet field parser testbench
// Feeds directed and random reply payloads under several capability settings
// and idle patterns; the checker predicts and compares every packet result.
// ----------------------------------------------------------------------------
module ok_packet_field_parser_top_test;
  import okp_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  in_item_t   in_data = '0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  out_item_t  out_data;
  logic       cfg_psel = 1'b0;
  logic       cfg_penable = 1'b0;
  logic       cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic       cfg_pready;
  int         fail_count, results_owed;

  // Local copy of the capability bits, so that payloads follow the layout the
  // block currently expects.
  logic       use_p41 = 1'b1, use_trans = 1'b0, use_sess = 1'b0;
  int         send_idle_pct = 0, pop_stall_pct = 0;
  int         hold_cycles = 0;
  int         quiet_cycles = 0;
  logic [7:0] payload[$];

  ok_packet_field_parser_top dut (.*);

  ok_packet_field_parser_checker checker_i (
    .clk, .rst_n, .in_push, .in_full, .in_data, .out_empty, .out_pop, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .results_owed
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver either stalls at random or, on request, holds off for a long
  // stretch so that the block backs up into its request side.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_pop <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Watchdog: any accepted request, result or register write counts as progress.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_psel || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    logic busy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{data_byte: b, last_byte: last};
    // in_full only moves at a rising edge, so its value at the falling edge
    // is the one the next rising edge acts on.
    do begin
      @(negedge clk);
      busy = in_full;
      @(posedge clk);
    end while (busy);
  endtask

  task automatic send_payload();
    foreach (payload[i]) send_byte(payload[i], i == payload.size() - 1);
    payload.delete();
  endtask

  // Registers are only written with the block drained and quiet.
  task automatic write_reg(input logic [1:0] idx, input logic v);
    in_push <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= {$urandom} & 32'hffff_fffe | 32'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_caps(input logic p41, trans, sess);
    write_reg(REG_PROTO41, p41);
    write_reg(REG_TRANS, trans);
    write_reg(REG_SESSTRK, sess);
    use_p41 = p41; use_trans = trans; use_sess = sess;
  endtask

  // Appends a length-encoded integer; sel picks the encoding, 4 makes it illegal.
  task automatic add_lenenc(input int sel, input logic [63:0] v);
    case (sel)
      0: payload.push_back((v[7:0] < PFX_NULL) ? v[7:0] : 8'hfa);
      1: begin
        payload.push_back(PFX_TWO);
        for (int k = 0; k < 2; k++) payload.push_back(v[8*k +: 8]);
      end
      2: begin
        payload.push_back(PFX_FOUR);
        for (int k = 0; k < 3; k++) payload.push_back(v[8*k +: 8]);
      end
      3: begin
        payload.push_back(PFX_EIGHT);
        for (int k = 0; k < 8; k++) payload.push_back(v[8*k +: 8]);
      end
      default: payload.push_back($urandom_range(1) ? PFX_NULL : 8'hff);
    endcase
  endtask

  function automatic int pick_enc();
    int r;
    r = $urandom_range(99);
    return (r < 55) ? 0 : (r < 70) ? 1 : (r < 83) ? 2 : (r < 97) ? 3 : 4;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Appends a string: a short declared length with its bytes, or now and then
  // a declared length far beyond the payload so that clamping is exercised.
  task automatic add_string();
    int len;
    if ($urandom_range(7) == 0) begin
      add_lenenc($urandom_range(1, 3), rand64() | 64'h100);
    end else begin
      len = $urandom_range(6);
      add_lenenc(0, 64'(len));
      repeat (len) payload.push_back(8'($urandom));
    end
  endtask

  // Builds one payload that follows the current layout, then sometimes cuts it.
  task automatic build_packet();
    logic [15:0] sw;
    int          cut;
    payload.push_back(8'($urandom));
    add_lenenc(pick_enc(), rand64());
    add_lenenc(pick_enc(), rand64());
    sw = 16'($urandom);
    if (use_p41 || use_trans) begin
      payload.push_back(sw[7:0]);
      payload.push_back(sw[15:8]);
    end
    if (use_p41) begin
      payload.push_back(8'($urandom));
      payload.push_back(8'($urandom));
    end
    if (use_sess) begin
      if ($urandom_range(5) != 0) add_string();
      if (sw[SESSION_CHANGED_BIT] && $urandom_range(3) != 0) add_string();
      repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0)
        payload.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(8)) payload.push_back(8'($urandom));
    end
    if ($urandom_range(4) == 0) begin
      cut = $urandom_range(1, payload.size());
      while (payload.size() > cut) void'(payload.pop_back());
    end
  endtask

  task automatic noise_packet();
    repeat ($urandom_range(1, 12)) payload.push_back(8'($urandom));
  endtask

  task automatic directed();
    // A payload too short to hold the fixed fields.
    payload = '{8'h00, 8'hff, 8'h01};
    send_payload();
    // Smallest complete reply with the all-ones status and warnings.
    payload = '{8'h00, 8'hfa, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff};
    send_payload();
    // Every wide prefix and a session flag with the payload ending in the info.
    payload = '{8'h00, 8'hfc, 8'h34, 8'h12, 8'hfd, 8'h01, 8'h02, 8'h03,
                8'h00, 8'h40, 8'h02, 8'h00, 8'h41};
    send_payload();
    payload = '{8'h00, 8'hfe, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_payload();
    // Bad prefixes, the second one followed by bytes that must be ignored.
    payload = '{8'h00, 8'hfb, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_payload();
    payload = '{8'h00, 8'h01, 8'hff, 8'hfc, 8'h00, 8'h00, 8'h00, 8'h00};
    send_payload();
    // Ending inside the eight-byte insert id.
    payload = '{8'h00, 8'h05, 8'hfe, 8'h01, 8'h02, 8'h03, 8'h04};
    send_payload();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();
    // Length-encoded strings, with a session string and a truncated prefix.
    set_caps(1'b1, 1'b0, 1'b1);
    payload = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00,
                8'h02, 8'h61, 8'h62, 8'h01, 8'h7a, 8'h99};
    send_payload();
    payload = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hfc, 8'h05};
    send_payload();
    // Status only, then neither word, with the remaining bytes taken as raw info.
    set_caps(1'b0, 1'b1, 1'b0);
    payload = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00};
    send_payload();
    set_caps(1'b0, 1'b0, 1'b0);
    payload = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06};
    send_payload();

    // Random phases: every capability setting once, then random settings, with the idle pattern taken in turn.
    for (int phase = 0; phase < 16; phase++) begin
      logic [2:0] caps;
      int         budget;
      caps = (phase < 8) ? 3'(phase) : 3'($urandom);
      set_caps(caps[0], caps[1], caps[2]);
      case (phase % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 56; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 56; end
        default: begin send_idle_pct = 38; pop_stall_pct = 38; end
      endcase
      // Long receiver hold while the sender keeps pushing, to fill the block.
      if (phase == 5) hold_cycles = 300;
      budget = 46;
      while (budget > 0) begin
        if ($urandom_range(9) == 0) noise_packet();
        else build_packet();
        budget -= payload.size();
        send_payload();
      end
    end

    in_push <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && results_owed == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
